[sv/cla_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types and constants of the CR LF line assembler.
// ----------------------------------------------------------------------------
package cla_pkg;

	localparam int LINE_STORE_DEPTH = 64;
	localparam int BYTE_W           = 8;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

	// control from the sequencer to the output stage
	typedef struct packed {
		logic rd_issue;    // a store read goes out this cycle
		logic rd_last;     // that read fetches the final byte of the line
		logic emit_empty;  // load the empty-line result
	} ctl_t;

	// status from the output stage back to the sequencer
	typedef struct packed {
		logic rd_ok;  // read stage is free next cycle
		logic in_ok;  // read stage empty and output register free next cycle
	} out_st_t;

endpackage

[sv/cla_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/cla_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_ctrl
// Collect/drain sequencer: stores line bytes, tracks CR, issues store reads.
// ----------------------------------------------------------------------------
module cla_ctrl #(
	parameter int DEPTH = cla_pkg::LINE_STORE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [cla_pkg::BYTE_W-1:0]  s_tdata,
	input  cla_pkg::out_st_t            stat,
	output cla_pkg::ctl_t               ctl,
	output logic                        ram_we,
	output logic [$clog2(DEPTH)-1:0]    ram_waddr,
	output logic [cla_pkg::BYTE_W-1:0]  ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(DEPTH)-1:0]    ram_raddr
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] CNT_MAX = AW'(DEPTH - 1);

	cla_pkg::state_t state_q, state_d;
	logic [AW-1:0]   count_q;
	logic [AW-1:0]   rd_ptr_q;
	logic            cr_q;
	logic            accept;
	logic            is_lf;
	logic            is_cr;
	logic            rd_at_last;

	assign accept     = s_tvalid && s_tready;
	assign is_lf      = (s_tdata == cla_pkg::CHAR_LF);
	assign is_cr      = (s_tdata == cla_pkg::CHAR_CR);
	assign rd_at_last = (rd_ptr_q == count_q - 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cla_pkg::ST_COLLECT: begin
				if (accept && cr_q && is_lf && (count_q != '0)) begin
					state_d = cla_pkg::ST_DRAIN;
				end
			end
			cla_pkg::ST_DRAIN: begin
				if (ctl.rd_issue && rd_at_last) begin
					state_d = cla_pkg::ST_COLLECT;
				end
			end
			default: state_d = cla_pkg::ST_COLLECT;
		endcase
	end

	// outputs
	always_comb begin
		s_tready       = 1'b0;
		ctl.rd_issue   = 1'b0;
		ctl.rd_last    = 1'b0;
		ctl.emit_empty = 1'b0;
		ram_we         = 1'b0;
		case (state_q)
			cla_pkg::ST_COLLECT: begin
				s_tready       = stat.in_ok;
				ctl.emit_empty = accept && cr_q && is_lf && (count_q == '0);
				ram_we         = accept && !cr_q && !is_cr;
			end
			cla_pkg::ST_DRAIN: begin
				ctl.rd_issue = stat.rd_ok;
				ctl.rd_last  = rd_at_last;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign ram_waddr = count_q;
	assign ram_wdata = s_tdata;
	assign ram_re    = ctl.rd_issue;
	assign ram_raddr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cla_pkg::ST_COLLECT;
			count_q  <= '0;
			rd_ptr_q <= '0;
			cr_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (cr_q) begin
					// LF closes the line; anything else drops it
					cr_q     <= 1'b0;
					rd_ptr_q <= '0;
					if (!is_lf) begin
						count_q <= '0;
					end
				end else if (is_cr) begin
					cr_q <= 1'b1;
				end else begin
					// a full store drops the line
					count_q <= (count_q == CNT_MAX) ? '0 : count_q + 1'b1;
				end
			end
			if (ctl.rd_issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				if (rd_at_last) begin
					count_q <= '0;
				end
			end
		end
	end

	a_drain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cla_pkg::ST_DRAIN |-> count_q != '0)
		else $error("drain with empty line store");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_issue |-> rd_ptr_q < count_q)
		else $error("store read beyond stored bytes");

	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == cla_pkg::ST_COLLECT && !ram_re)
		else $error("store write overlaps drain");

endmodule

[sv/cla_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_out
// Read-data stage and output register of the line assembler.
// ----------------------------------------------------------------------------
module cla_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cla_pkg::ctl_t              ctl,
	input  logic [cla_pkg::BYTE_W-1:0] ram_rdata,
	output cla_pkg::out_st_t           stat,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cla_pkg::BYTE_W-1:0] m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);

	logic s1_v_q;
	logic s1_last_q;
	logic m_free;
	logic move;

	assign m_free = !m_tvalid || m_tready;
	assign move   = s1_v_q && m_free;

	assign stat.rd_ok = !s1_v_q || move;
	assign stat.in_ok = !s1_v_q && m_free;

	// read stage: RAM data holds while no new read is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (ctl.rd_issue) begin
			s1_v_q <= 1'b1;
		end else if (move) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_issue) begin
			s1_last_q <= ctl.rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (move || ctl.emit_empty) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			m_tdata <= ram_rdata;
			m_tlast <= s1_last_q;
			m_tuser <= 1'b0;
		end else if (ctl.emit_empty) begin
			m_tdata <= '0;
			m_tlast <= 1'b1;
			m_tuser <= 1'b1;
		end
	end

	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_empty |-> !s1_v_q && m_free)
		else $error("empty-line result collides with pending data");

	a_issue_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_issue |-> !s1_v_q || move)
		else $error("read issued into a stalled stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !move |=> s1_v_q)
		else $error("read stage lost data");

endmodule

[sv/crlf_line_assembler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_line_assembler
// Assembles received bytes into lines ended by CR LF and streams them out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata           | tlast | tuser
//  ---------+-----+-----------------+-------+------------
//  s_       | in  | [7:0] rx_byte   | -     | -
//  m_       | out | [7:0] line_byte | last  | empty_line
//
//  Flow: one received byte per cycle while collecting and intake is not held.
//  A CR LF closing a line of N bytes stalls intake while the line store is read
//  out one byte per cycle unless backpressure holds it; each byte passes the
//  store read and the read stage; an empty line's single result skips both.
//  Reset: arst_n clears the byte count, the CR flag, the sequencer and the
//  output valid; the line store is not cleared (only written entries are read).
//  Stalls: m_tready backpressure holds the output register, the read stage and
//  the store reads without losing data; intake is held while the read stage
//  holds a byte or the output register holds a transaction not being taken.
//
module crlf_line_assembler #(
	parameter int LINE_STORE_DEPTH = cla_pkg::LINE_STORE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [cla_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cla_pkg::BYTE_W-1:0] m_tdata,   // [7:0] line_byte
	output logic                       m_tlast,
	output logic                       m_tuser    // [0] empty_line
);

	localparam int AW = $clog2(LINE_STORE_DEPTH);

	cla_pkg::ctl_t              ctl;
	cla_pkg::out_st_t           stat;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [cla_pkg::BYTE_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [cla_pkg::BYTE_W-1:0] ram_rdata;

	// sequencer: store bytes, watch for CR LF, walk the store on drain
	cla_ctrl #(
		.DEPTH(LINE_STORE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.stat     (stat),
		.ctl      (ctl),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr)
	);

	// line store
	cla_ram #(
		.WIDTH(cla_pkg::BYTE_W),
		.DEPTH(LINE_STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// hold read data and present each transaction on the master side
	cla_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ram_rdata(ram_rdata),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

[bench/tb_crlf_line_assembler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crlf_line_assembler
// Self-checking bench for the CR LF line assembler: streams received bytes in,
// predicts every emitted line byte and compares the output stream field by field.
// ----------------------------------------------------------------------------
module tb_crlf_line_assembler;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BYTES = 80;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_LINE    = cla_pkg::LINE_STORE_DEPTH - 1;

	// kinds of entry in the pending stimulus queue
	typedef enum logic [1:0] {
		ENT_BYTE,   // offer one received byte
		ENT_DRAIN,  // hold the sender until every expected line byte has come
		ENT_MODE    // switch the idle and stall rates
	} ent_kind_t;

	typedef struct {
		ent_kind_t  kind;
		logic [7:0] val;
		int         send_pct;
		int         stall_pct;
	} stim_ent_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       last;
		logic       empty_line;
	} line_result_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [7:0] rx_byte
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [7:0] line_byte
	logic       m_tlast;
	logic       m_tuser;    // [0] empty_line

	stim_ent_t    stim_q[$];
	line_result_t line_q[$];

	// line predictor state
	logic [7:0] line_buf [cla_pkg::LINE_STORE_DEPTH];
	int         held_cnt = 0;
	bit         cr_seen  = 1'b0;

	int offer_cnt     = 0;
	int taken_cnt     = 0;
	int err_cnt       = 0;
	int cycle_cnt     = 0;
	int byte_total    = 0;
	int send_idle_pct = 0;
	int rx_stall_pct  = 0;

	crlf_line_assembler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the predicted line state by one accepted byte and queue the line
	// bytes it releases.
	task automatic absorb_byte(input logic [7:0] b);
		int k;
		if (cr_seen) begin
			if (b == cla_pkg::CHAR_LF) begin
				if (held_cnt == 0) begin
					line_q.push_back('{line_byte: 8'h00, last: 1'b1, empty_line: 1'b1});
				end else begin
					for (k = 0; k < held_cnt; k++)
						line_q.push_back('{line_byte: line_buf[k],
						                   last: (k == held_cnt - 1),
						                   empty_line: 1'b0});
				end
			end
			// anything but LF after CR drops the line and the byte itself
			held_cnt = 0;
			cr_seen  = 1'b0;
		end else if (b == cla_pkg::CHAR_CR) begin
			cr_seen = 1'b1;
		end else begin
			line_buf[held_cnt] = b;
			held_cnt++;
			// a full store drops the line
			if (held_cnt >= cla_pkg::LINE_STORE_DEPTH)
				held_cnt = 0;
		end
	endtask

	task automatic queue_byte(input logic [7:0] b);
		stim_q.push_back('{kind: ENT_BYTE, val: b, send_pct: 0, stall_pct: 0});
		byte_total++;
	endtask

	task automatic queue_drain();
		stim_q.push_back('{kind: ENT_DRAIN, val: 8'h00, send_pct: 0, stall_pct: 0});
	endtask

	task automatic queue_mode(input int send_pct, input int stall_pct);
		stim_q.push_back('{kind: ENT_MODE, val: 8'h00, send_pct: send_pct,
		                   stall_pct: stall_pct});
	endtask

	// any byte but CR, with LF showing up now and then as plain data
	function automatic logic [7:0] line_data();
		logic [7:0] b;
		b = ($urandom_range(15) == 0) ? cla_pkg::CHAR_LF : 8'($urandom_range(255));
		while (b == cla_pkg::CHAR_CR)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	task automatic queue_line(input int len);
		int i;
		for (i = 0; i < len; i++)
			queue_byte(line_data());
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(cla_pkg::CHAR_LF);
	endtask

	// One phase of random traffic: mostly well-formed lines, the rest broken
	// lines and raw noise, then a pause until the output side has caught up.
	task automatic run_phase(input int send_pct, input int stall_pct);
		int target;
		int pick;
		int i;
		int n;
		logic [7:0] b;
		queue_mode(send_pct, stall_pct);
		target = byte_total + PHASE_BYTES;
		while (byte_total < target) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				queue_line(MAX_LINE);
			end else if (pick < 5) begin
				// overrun the store, then restart the line from index zero
				queue_line(cla_pkg::LINE_STORE_DEPTH + $urandom_range(3));
			end else if (pick < 50) begin
				queue_line($urandom_range(8));
			end else if (pick < 70) begin
				queue_line($urandom_range(24));
			end else if (pick < 85) begin
				// CR followed by something other than LF
				n = $urandom_range(6);
				for (i = 0; i < n; i++)
					queue_byte(line_data());
				queue_byte(cla_pkg::CHAR_CR);
				b = ($urandom_range(3) == 0) ? cla_pkg::CHAR_CR : 8'($urandom_range(255));
				while (b == cla_pkg::CHAR_LF)
					b = 8'($urandom_range(255));
				queue_byte(b);
			end else begin
				n = $urandom_range(5, 1);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(3))
						0: queue_byte(cla_pkg::CHAR_CR);
						1: queue_byte(cla_pkg::CHAR_LF);
						default: queue_byte(8'($urandom_range(255)));
					endcase
				end
			end
		end
		queue_drain();
	endtask

	// Sender: hold an offered transaction until it is taken, otherwise advance
	// through the pending queue at the falling edge.
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && taken_cnt != offer_cnt)) begin
			if (stim_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				case (stim_q[0].kind)
					ENT_MODE: begin
						send_idle_pct <= stim_q[0].send_pct;
						rx_stall_pct  <= stim_q[0].stall_pct;
						stim_q.delete(0);
						s_tvalid <= 1'b0;
					end
					ENT_DRAIN: begin
						if (line_q.size() == 0)
							stim_q.delete(0);
						s_tvalid <= 1'b0;
					end
					default: begin
						if ($urandom_range(99) < send_idle_pct) begin
							s_tvalid <= 1'b0;
						end else begin
							s_tdata  <= stim_q[0].val;
							s_tvalid <= 1'b1;
							stim_q.delete(0);
							offer_cnt++;
						end
					end
				endcase
			end
		end
	end

	// Receiver: stall at the rate of the current phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Monitor: predict on every input transaction, check every output transaction.
	always @(posedge clk) begin : monitor
		line_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				absorb_byte(s_tdata);
				taken_cnt <= taken_cnt + 1;
			end
			if (m_tvalid && m_tready) begin
				if (line_q.size() == 0) begin
					$error("unexpected output: line_byte %02h last %0b empty_line %0b",
					       m_tdata, m_tlast, m_tuser);
					err_cnt++;
				end else begin
					want = line_q.pop_front();
					if (m_tdata !== want.line_byte) begin
						$error("line_byte mismatch: expected %02h, got %02h",
						       want.line_byte, m_tdata);
						err_cnt++;
					end
					if (m_tlast !== want.last) begin
						$error("last mismatch: expected %0b, got %0b", want.last, m_tlast);
						err_cnt++;
					end
					if (m_tuser !== want.empty_line) begin
						$error("empty_line mismatch: expected %0b, got %0b",
						       want.empty_line, m_tuser);
						err_cnt++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		m_tready = 1'b0;

		// directed: empty line
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(cla_pkg::CHAR_LF);
		// byte extremes, LF as plain data inside a line
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(cla_pkg::CHAR_LF);
		queue_byte(8'h55);
		queue_byte(8'haa);
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(cla_pkg::CHAR_LF);
		// data after CR drops the line and that byte, then an empty line
		queue_byte(8'h41);
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(8'h42);
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(cla_pkg::CHAR_LF);
		// CR after CR drops the line, then a one-byte line
		queue_byte(8'h43);
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(8'h44);
		queue_byte(cla_pkg::CHAR_CR);
		queue_byte(cla_pkg::CHAR_LF);
		queue_drain();

		run_phase(0, 0);
		run_phase(80, 0);
		run_phase(0, 80);
		run_phase(27, 27);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (stim_q.size() == 0 && taken_cnt == offer_cnt);
		wait (line_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_cnt == 0 && line_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
